// ===== design/depth_box_blur_nearest_point_unit_defines.svh =====
// Assertion macros for the depth box blur nearest point unit.
// Used by the port-level checker; no other dependencies.
`ifndef DEPTH_BOX_BLUR_NEAREST_POINT_UNIT_DEFINES_SVH
`define DEPTH_BOX_BLUR_NEAREST_POINT_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define DBB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dbbnp check failed");

// Signal holds while a beat is offered and not taken.
`define DBB_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> $stable(sig)) \
    else $error("dbbnp stalled signal changed");

`endif

// ===== design/dbbnp_pkg.sv =====
// Shared types and constants for the depth box blur nearest point unit.
// No dependencies.
package dbbnp_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int DEPTH_W   = 16;
  localparam int SUM_W     = 20;
  localparam int OUT_W     = 136;

  // reciprocal of 9 in Q24, exact for sums below 2^21
  localparam logic [20:0] DIV9_MUL = 21'd1864136;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;
  localparam logic [15:0] RST_FILL   = 16'd4000;
  localparam logic [15:0] RST_CX     = 16'd5429;
  localparam logic [15:0] RST_CY     = 16'd3884;
  localparam logic [23:0] RST_IFX    = 24'd28235;
  localparam logic [23:0] RST_IFY    = 24'd28386;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_FILL   = 3'd2,
    CFG_CX     = 3'd3,
    CFG_CY     = 3'd4,
    CFG_IFX    = 3'd5,
    CFG_IFY    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_FIN,
    ST_PROJ
  } state_e;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [23:0]        ifx;
    logic [23:0]        ify;
  } proj_req_t;

endpackage

// ===== design/dbbnp_proj.sv =====
// Pinhole projection of the nearest point: ((pos*16-center)*inv_f*depth)>>>24, saturated.
// Depends on dbbnp_pkg. Capture, two multiplies, saturate; result held until next start.
module dbbnp_proj import dbbnp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  proj_req_t        req_i,
  output logic             done_o,
  output logic [31:0]      x_o,
  output logic [31:0]      y_o
);

  logic [2:0]          stage_q, stage_d;
  logic                done_q, done_d;
  logic signed [17:0]  dx_q, dy_q;
  logic signed [16:0]  dep_q;
  logic signed [24:0]  ifx_q, ify_q;
  logic signed [34:0]  ax_q, ay_q;
  logic signed [59:0]  px_q, py_q;
  logic [31:0]         x_q, y_q;

  function automatic logic [31:0] sat32(input logic signed [59:0] p);
    logic signed [35:0] s;
    s = p[59:24];
    if (s > 36'sd2147483647) return 32'h7FFF_FFFF;
    else if (s < -36'sd2147483648) return 32'h8000_0000;
    else return s[31:0];
  endfunction

  always_comb begin
    stage_d = {stage_q[1:0], start_i};
    done_d  = done_q;
    if (start_i) done_d = 1'b0;
    else if (stage_q[2]) done_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= stage_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q  <= $signed({4'b0, req_i.col, 4'b0}) - $signed({2'b0, req_i.cx});
      dy_q  <= $signed({2'b0, req_i.row, 4'b0}) - $signed({2'b0, req_i.cy});
      dep_q <= $signed({1'b0, req_i.depth});
      ifx_q <= $signed({1'b0, req_i.ifx});
      ify_q <= $signed({1'b0, req_i.ify});
    end
    if (stage_q[0]) begin
      ax_q <= dx_q * dep_q;
      ay_q <= dy_q * dep_q;
    end
    if (stage_q[1]) begin
      px_q <= ax_q * ifx_q;
      py_q <= ay_q * ify_q;
    end
    if (stage_q[2]) begin
      x_q <= sat32(px_q);
      y_q <= sat32(py_q);
    end
  end

  // the previous result is no longer done once a new start is seen
  assign done_o = done_q && !start_i;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ===== design/depth_box_blur_nearest_point_unit.sv =====
// Depth box blur nearest point unit: 3x3 rounded box mean over a depth stream,
// strict minimum search, projection of the winner at frame end.
// Each pixel passes accept, load, then a window sum and divide-by-9 step per filtered
// value (none to four), then the column and row advance. Input waits while a frame's
// projection is in progress.
// Reset loads defaults, clears counters, sets bests to max; line stores are not cleared.
module depth_box_blur_nearest_point_unit import dbbnp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // depth_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // near_col, near_row, near_depth, x_q4, y_q4, frame_number, zero pad
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i
);

  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [15:0] fill_q, cx_q, cy_q;
  logic [23:0] ifx_q, ify_q;

  state_e state_q, state_d;

  logic [DEPTH_W-1:0] upper_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] lower_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] rd_upper_q, rd_lower_q, pix_q;
  logic [DEPTH_W-1:0] win_q [9];

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [DEPTH_W-1:0] best_dep_q, best_dep_d, tail_dep_q, tail_dep_d;
  logic [COL_W-1:0]   best_col_q, best_col_d, tail_col_q, tail_col_d;
  logic [ROW_W-1:0]   best_row_q, best_row_d;
  logic [31:0]        frame_q, frame_d;
  logic [1:0]         step_q, step_d;
  logic               end_col_q, end_row_q;
  logic [SUM_W-1:0]   sum_q;
  logic               out_vld_q, out_vld_d;
  logic [OUT_W-1:0]   out_q;

  logic [10:0]        w_eff;
  logic [11:0]        h_eff;
  logic               end_col, end_row, accept, proj_start, proj_done;
  logic [31:0]        px, py;
  proj_req_t          req_q, req_d;
  logic [40:0]        prod;
  logic [DEPTH_W-1:0] mean;
  logic [COL_W-1:0]   emit_col;
  logic [1:0]         cl, cm, cr, rt, rm, rb;
  logic [SUM_W-1:0]   sum_d;

  function automatic logic [DEPTH_W-1:0] pick(input logic [DEPTH_W-1:0] w [9],
                                              input logic [1:0] c, input logic [1:0] r);
    logic [3:0] i;
    i = 4'(c) * 4'd3 + 4'(r);
    return w[i];
  endfunction

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      fill_q   <= RST_FILL;
      cx_q     <= RST_CX;
      cy_q     <= RST_CY;
      ifx_q    <= RST_IFX;
      ify_q    <= RST_IFY;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i[11:0];
        CFG_FILL:   fill_q   <= cfg_data_i[15:0];
        CFG_CX:     cx_q     <= cfg_data_i[15:0];
        CFG_CY:     cy_q     <= cfg_data_i[15:0];
        CFG_IFX:    ifx_q    <= cfg_data_i;
        CFG_IFY:    ify_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_q;
    if (width_q < 11'd2) w_eff = 11'd2;
    else if (width_q > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    h_eff = (height_q < 12'd2) ? 12'd2 : height_q;
  end
  assign end_col = {1'b0, col_q} >= (w_eff - 11'd1);
  assign end_row = row_q >= (h_eff - 12'd1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // line stores: read on accept, write back in the next cycle (ST_LOAD)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_upper_q <= upper_mem[col_q[ADDR_W-1:0]];
      rd_lower_q <= lower_mem[col_q[ADDR_W-1:0]];
      pix_q      <= (s_axis_tdata == 16'd0) ? fill_q : s_axis_tdata;
    end
    if (state_q == ST_LOAD) begin
      upper_mem[col_q[ADDR_W-1:0]] <= rd_lower_q;
      lower_mem[col_q[ADDR_W-1:0]] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
      end_col_q <= 1'b0;
      end_row_q <= 1'b0;
    end else if (state_q == ST_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k]   <= win_q[3+k];
        win_q[3+k] <= win_q[6+k];
      end
      win_q[6]  <= rd_upper_q;
      win_q[7]  <= rd_lower_q;
      win_q[8]  <= pix_q;
      end_col_q <= end_col;
      end_row_q <= end_row;
    end
  end

  // window column and row selection, mirrored at borders
  always_comb begin
    if (!step_q[1]) begin
      cl = (col_q >= COL_W'(2)) ? 2'd0 : 2'd2;
      cm = 2'd1;
      cr = 2'd2;
    end else begin
      cl = 2'd1;
      cm = 2'd2;
      cr = 2'd1;
    end
    if (!step_q[0]) begin
      rt = (row_q >= ROW_W'(2)) ? 2'd0 : 2'd2;
      rm = 2'd1;
      rb = 2'd2;
    end else begin
      rt = 2'd1;
      rm = 2'd2;
      rb = 2'd1;
    end
    sum_d = SUM_W'(pick(win_q, cl, rt)) + SUM_W'(pick(win_q, cl, rm))
          + SUM_W'(pick(win_q, cl, rb)) + SUM_W'(pick(win_q, cm, rt))
          + SUM_W'(pick(win_q, cm, rm)) + SUM_W'(pick(win_q, cm, rb))
          + SUM_W'(pick(win_q, cr, rt)) + SUM_W'(pick(win_q, cr, rm))
          + SUM_W'(pick(win_q, cr, rb));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) sum_q <= sum_d;
  end

  assign prod     = 41'(sum_q + SUM_W'(4)) * 41'(DIV9_MUL);
  assign mean     = prod[39:24];
  assign emit_col = step_q[1] ? col_q : col_q - COL_W'(1);

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    best_dep_d = best_dep_q;
    best_col_d = best_col_q;
    best_row_d = best_row_q;
    tail_dep_d = tail_dep_q;
    tail_col_d = tail_col_q;
    frame_d    = frame_q;
    step_d     = step_q;
    out_vld_d  = out_vld_q;
    req_d      = req_q;
    proj_start = 1'b0;
    if (m_axis_tvalid && m_axis_tready) out_vld_d = 1'b0;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOAD;
      ST_LOAD: begin
        step_d  = 2'd0;
        state_d = (row_q != '0 && col_q != '0) ? ST_SUM : ST_FIN;
      end
      ST_SUM: state_d = ST_DIV;
      ST_DIV: begin
        if (!step_q[0]) begin
          if (mean < best_dep_q) begin
            best_dep_d = mean;
            best_col_d = emit_col;
            best_row_d = row_q - ROW_W'(1);
          end
        end else if (mean < tail_dep_q) begin
          tail_dep_d = mean;
          tail_col_d = emit_col;
        end
        state_d = ST_FIN;
        case (step_q)
          2'd0: begin
            if (end_row_q) begin
              step_d = 2'd1; state_d = ST_SUM;
            end else if (end_col_q) begin
              step_d = 2'd2; state_d = ST_SUM;
            end
          end
          2'd1: if (end_col_q) begin
            step_d = 2'd2; state_d = ST_SUM;
          end
          2'd2: if (end_row_q) begin
            step_d = 2'd3; state_d = ST_SUM;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        if (!end_col_q) begin
          col_d = col_q + COL_W'(1);
        end else begin
          col_d = '0;
          if (end_row_q) begin
            req_d.col   = best_col_q;
            req_d.row   = best_row_q;
            req_d.depth = best_dep_q;
            if (tail_dep_q < best_dep_q) begin
              req_d.col   = tail_col_q;
              req_d.row   = row_q;
              req_d.depth = tail_dep_q;
            end
            req_d.cx   = cx_q;
            req_d.cy   = cy_q;
            req_d.ifx  = ifx_q;
            req_d.ify  = ify_q;
            frame_d    = frame_q + 32'd1;
            row_d      = '0;
            best_dep_d = '1;
            best_col_d = '0;
            best_row_d = '0;
            tail_dep_d = '1;
            tail_col_d = '0;
            state_d    = ST_PROJ;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      ST_PROJ: begin
        proj_start = 1'b0;
        if (proj_done && !out_vld_q) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // kick the projection from a flag registered at the same edge as the request registers
  logic proj_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) proj_go_q <= 1'b0;
    else proj_go_q <= (state_q == ST_FIN) && (state_d == ST_PROJ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      best_dep_q <= '1;
      best_col_q <= '0;
      best_row_q <= '0;
      tail_dep_q <= '1;
      tail_col_q <= '0;
      frame_q    <= '0;
      step_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      best_dep_q <= best_dep_d;
      best_col_q <= best_col_d;
      best_row_q <= best_row_d;
      tail_dep_q <= tail_dep_d;
      tail_col_q <= tail_col_d;
      frame_q    <= frame_d;
      step_q     <= step_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (state_q == ST_PROJ && proj_done && !out_vld_q) begin
      out_q <= {2'b0, frame_q, py, px, req_q.depth, req_q.row, req_q.col};
    end
  end

  dbbnp_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (proj_go_q | proj_start),
    .req_i   (req_q),
    .done_o  (proj_done),
    .x_o     (px),
    .y_o     (py)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== design/dbbnp_checker.sv =====
// Port-level checker for the depth box blur nearest point unit, bound to the top.
// Depends on dbbnp_pkg and the assertion macros header.
`include "depth_box_blur_nearest_point_unit_defines.svh"

module dbbnp_checker import dbbnp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [15:0]      s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [2:0]       cfg_index_i,
  input logic [23:0]      cfg_data_i
);

  `DBB_ASSERT(a_out_valid_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `DBB_ASSERT_HOLD(a_out_data_holds, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `DBB_ASSERT(a_busy_after_beat, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `DBB_ASSERT(a_one_result_at_a_time, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)

endmodule

bind depth_box_blur_nearest_point_unit dbbnp_checker u_dbbnp_checker (.*);
